### src/rtp_pkg.sv
// ============================================================================
// rtp_pkg
// Shared types, character codes and the note frequency table.
// ============================================================================
package rtp_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_G  = 8'h67;
    localparam logic [7:0] CH_LC_O  = 8'h6F;

    localparam logic [3:0] PH_NAME   = 4'd0;
    localparam logic [3:0] PH_KEY    = 4'd1;
    localparam logic [3:0] PH_D_EQ   = 4'd2;
    localparam logic [3:0] PH_D_VAL  = 4'd3;
    localparam logic [3:0] PH_O_EQ   = 4'd4;
    localparam logic [3:0] PH_O_VAL  = 4'd5;
    localparam logic [3:0] PH_B_EQ   = 4'd6;
    localparam logic [3:0] PH_B_VAL  = 4'd7;
    localparam logic [3:0] PH_DUR    = 4'd8;
    localparam logic [3:0] PH_LETTER = 4'd9;
    localparam logic [3:0] PH_SHARP  = 4'd10;
    localparam logic [3:0] PH_DOT    = 4'd11;
    localparam logic [3:0] PH_OCT    = 4'd12;

    localparam logic [9:0]  NUM_MAX    = 10'd999;
    localparam logic [9:0]  RST_LENGTH = 10'd4;
    localparam logic [2:0]  RST_OCTAVE = 3'd6;
    localparam logic [9:0]  RST_TEMPO  = 10'd63;
    localparam logic [22:0] MS_PER_MIN = 23'd60000;
    // Hold time is duration * 6 / 5, taken as (duration * HOLD_MUL) >> 24.
    localparam logic [24:0] HOLD_MUL   = 25'd20132664;
    localparam int          DIV_STEPS  = 23;

    localparam logic [1:0] SEL_HDR = 2'd0;
    localparam logic [1:0] SEL_DUR = 2'd1;
    localparam logic [1:0] SEL_TEN = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       start;
        logic [1:0] sel;
        logic       load_whole;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic hdr_need;
        logic emit_note;
        logic emit_any;
        logic e_note;
        logic div_done;
        logic out_full;
    } t_sts;

    function automatic logic [11:0] freq_lookup(input logic [5:0] idx);
        logic [11:0] f;
        case (idx)
            6'd1:  f = 12'd262;  6'd2:  f = 12'd277;  6'd3:  f = 12'd294;
            6'd4:  f = 12'd311;  6'd5:  f = 12'd330;  6'd6:  f = 12'd349;
            6'd7:  f = 12'd370;  6'd8:  f = 12'd392;  6'd9:  f = 12'd415;
            6'd10: f = 12'd440;  6'd11: f = 12'd466;  6'd12: f = 12'd494;
            6'd13: f = 12'd523;  6'd14: f = 12'd554;  6'd15: f = 12'd587;
            6'd16: f = 12'd622;  6'd17: f = 12'd659;  6'd18: f = 12'd698;
            6'd19: f = 12'd740;  6'd20: f = 12'd784;  6'd21: f = 12'd831;
            6'd22: f = 12'd880;  6'd23: f = 12'd932;  6'd24: f = 12'd988;
            6'd25: f = 12'd1047; 6'd26: f = 12'd1109; 6'd27: f = 12'd1175;
            6'd28: f = 12'd1245; 6'd29: f = 12'd1319; 6'd30: f = 12'd1397;
            6'd31: f = 12'd1480; 6'd32: f = 12'd1568; 6'd33: f = 12'd1661;
            6'd34: f = 12'd1760; 6'd35: f = 12'd1865; 6'd36: f = 12'd1976;
            6'd37: f = 12'd2093; 6'd38: f = 12'd2217; 6'd39: f = 12'd2349;
            6'd40: f = 12'd2489; 6'd41: f = 12'd2637; 6'd42: f = 12'd2794;
            6'd43: f = 12'd2960; 6'd44: f = 12'd3136; 6'd45: f = 12'd3322;
            6'd46: f = 12'd3520; 6'd47: f = 12'd3729; 6'd48: f = 12'd3951;
            default: f = 12'd0;
        endcase
        return f;
    endfunction

endpackage

### src/rtp_ctrl.sv
// ============================================================================
// rtp_ctrl
// Sequencer: takes a character, then runs the divider steps and loads the
// output register.
// ============================================================================
module rtp_ctrl
    import rtp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HDR_GO = 3'd1;
    localparam logic [2:0] S_HDR    = 3'd2;
    localparam logic [2:0] S_DUR_GO = 3'd3;
    localparam logic [2:0] S_DUR    = 3'd4;
    localparam logic [2:0] S_TEN_GO = 3'd5;
    localparam logic [2:0] S_TEN    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.hdr_need) n_state = S_HDR_GO;
                    else if (i_sts.emit_note) n_state = S_DUR_GO;
                    else if (i_sts.emit_any) n_state = S_OUT;
                end
            end
            S_HDR_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.sel   = SEL_HDR;
                n_state     = S_HDR;
            end
            S_HDR: begin
                if (i_sts.div_done) begin
                    o_cmd.load_whole = 1'b1;
                    n_state = i_sts.e_note ? S_DUR_GO : S_IDLE;
                end
            end
            S_DUR_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.sel   = SEL_DUR;
                n_state     = S_DUR;
            end
            S_DUR: begin
                if (i_sts.div_done) n_state = S_TEN_GO;
            end
            S_TEN_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.sel   = SEL_TEN;
                n_state     = S_TEN;
            end
            S_TEN: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/rtp_dpath.sv
// ============================================================================
// rtp_dpath
// Parse state, note snapshot, shared restoring divider and output register.
// ============================================================================
module rtp_dpath
    import rtp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_ch,
    input  logic        i_fin,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [11:0] o_freq,
    output logic [18:0] o_hold,
    output logic        o_rest,
    output logic        o_err,
    output logic        o_last
);

    logic [3:0]  r_ph;
    logic [9:0]  r_dl;
    logic [2:0]  r_do;
    logic [9:0]  r_tb;
    logic [17:0] r_wn;
    logic [9:0]  r_acc;
    logic [3:0]  r_pn;
    logic        r_dot;
    logic [3:0]  r_po;
    logic        r_og;

    logic [17:0] r_e_whole;
    logic [9:0]  r_e_div;
    logic [9:0]  r_e_bpm;
    logic        r_e_dot;
    logic [11:0] r_e_freq;
    logic        r_e_rest;
    logic        r_e_err;
    logic        r_e_fin;
    logic        r_e_plain;
    logic        r_e_note;

    logic [10:0] r_rem;
    logic [22:0] r_quo;
    logic [9:0]  r_dvsr;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic        r_o_valid;
    logic [11:0] r_o_freq;
    logic [18:0] r_o_hold;
    logic        r_o_rest;
    logic        r_o_err;
    logic        r_o_last;

    logic [3:0]  n_ph;
    logic [9:0]  n_dl;
    logic [2:0]  n_do;
    logic [9:0]  n_tb;
    logic [9:0]  n_acc;
    logic [3:0]  n_pn;
    logic        n_dot;
    logic [3:0]  n_po;
    logic        n_og;
    logic        hdr_fin;
    logic        emit_note;
    logic        cap_dot;
    logic [9:0]  cap_div;
    logic [8:0]  cap_idx;
    logic        cap_noted;
    logic        digit;
    logic [3:0]  dval;
    logic [13:0] acc_x10;
    logic [3:0]  scale;
    logic [9:0]  tmp_bpm;

    assign digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign dval  = 4'(i_ch - CH_ZERO);
    assign acc_x10 = 14'({r_acc, 3'b0}) + 14'({r_acc, 1'b0}) + 14'(dval);

    always_comb begin
        n_ph = r_ph; n_dl = r_dl; n_do = r_do; n_tb = r_tb;
        n_acc = r_acc; n_pn = r_pn; n_dot = r_dot; n_po = r_po; n_og = r_og;
        hdr_fin = 1'b0; emit_note = 1'b0;
        cap_dot = 1'b0; cap_div = RST_LENGTH; cap_idx = '0; cap_noted = 1'b0;
        scale = '0;
        tmp_bpm = r_tb;
        case (r_ph)
            PH_KEY: begin
                n_acc = '0;
                if (i_ch == CH_LC_D) n_ph = PH_D_EQ;
                else if (i_ch == CH_LC_O) n_ph = PH_O_EQ;
                else if (i_ch == CH_LC_B) n_ph = PH_B_EQ;
                else hdr_fin = 1'b1;
            end
            PH_D_EQ, PH_O_EQ, PH_B_EQ: begin
                n_acc = '0;
                n_ph  = r_ph + 4'd1;
            end
            PH_D_VAL, PH_O_VAL, PH_B_VAL: begin
                if (digit) begin
                    n_acc = (acc_x10 > 14'(NUM_MAX)) ? NUM_MAX : acc_x10[9:0];
                end else begin
                    if (r_ph == PH_D_VAL) begin
                        if (r_acc != '0) n_dl = r_acc;
                    end else if (r_ph == PH_O_VAL) begin
                        if (r_acc >= 10'd3 && r_acc <= 10'd7) n_do = r_acc[2:0];
                    end else begin
                        n_tb = (r_acc == '0) ? 10'd1 : r_acc;
                    end
                    if (r_ph == PH_B_VAL || i_ch == CH_COLON) begin
                        hdr_fin = 1'b1;
                    end else begin
                        n_acc = '0;
                        n_ph  = PH_KEY;
                    end
                end
            end
            PH_DUR: ;
            PH_LETTER, PH_SHARP, PH_DOT, PH_OCT: begin
                if (i_ch == CH_COMMA) begin
                    emit_note = 1'b1;
                end else if (i_ch == CH_SHARP && r_ph == PH_LETTER) begin
                    if (r_pn != '0) n_pn = r_pn + 4'd1;
                    n_ph = PH_SHARP;
                end else if (i_ch == CH_DOT && r_ph <= PH_SHARP) begin
                    n_dot = 1'b1;
                    n_ph  = PH_DOT;
                end else if (digit && r_ph <= PH_DOT) begin
                    n_po = dval;
                    n_og = 1'b1;
                    n_ph = PH_OCT;
                end
            end
            default: begin
                if (i_ch == CH_COLON) begin
                    n_acc = '0;
                    n_ph  = PH_KEY;
                end
            end
        endcase
        if (hdr_fin) begin
            n_tb = (n_tb == '0) ? 10'd1 : n_tb;
            n_acc = '0; n_pn = '0; n_dot = 1'b0; n_po = '0; n_og = 1'b0;
            n_ph = PH_DUR;
        end
        tmp_bpm = n_tb;
        if ((r_ph == PH_DUR) || (r_ph == PH_KEY && hdr_fin)) begin
            if (digit) begin
                n_acc = (acc_x10 > 14'(NUM_MAX)) ? NUM_MAX : acc_x10[9:0];
            end else begin
                case (i_ch)
                    CH_LC_C: n_pn = 4'd1;
                    CH_LC_D: n_pn = 4'd3;
                    CH_LC_E: n_pn = 4'd5;
                    CH_LC_F: n_pn = 4'd6;
                    CH_LC_G: n_pn = 4'd8;
                    CH_LC_A: n_pn = 4'd10;
                    CH_LC_B: n_pn = 4'd12;
                    default: n_pn = 4'd0;
                endcase
                n_ph = PH_LETTER;
            end
        end
        if (!emit_note && i_fin && n_ph >= PH_LETTER && n_ph <= PH_OCT) begin
            emit_note = 1'b1;
        end
        if (emit_note) begin
            cap_div   = (n_acc != '0) ? n_acc : n_dl;
            cap_dot   = n_dot;
            scale     = n_og ? n_po : {1'b0, n_do};
            cap_idx   = 9'({scale, 3'b0}) + 9'({scale, 2'b0}) + 9'(n_pn) - 9'd48;
            cap_noted = (n_pn != '0);
            n_acc = '0; n_pn = '0; n_dot = 1'b0; n_po = '0; n_og = 1'b0;
            n_ph = PH_DUR;
        end
    end

    logic        idx_ok;
    logic [10:0] rem_sh;
    logic        fits;
    logic [17:0] q18;
    logic [18:0] dur;
    logic [43:0] hold_prod;
    logic [22:0] ld_dvd;
    logic [9:0]  ld_dvsr;

    assign idx_ok    = !cap_idx[8] && (cap_idx != '0) && (cap_idx <= 9'd48);
    assign rem_sh    = {r_rem[9:0], r_quo[22]};
    assign fits      = rem_sh >= {1'b0, r_dvsr};
    assign q18       = r_quo[17:0];
    assign dur       = {1'b0, q18} + (r_e_dot ? {2'b0, q18[17:1]} : 19'd0);
    assign hold_prod = 44'(dur) * 44'(HOLD_MUL);

    always_comb begin
        case (i_cmd.sel)
            SEL_HDR: begin ld_dvd = MS_PER_MIN;        ld_dvsr = r_e_bpm; end
            default: begin ld_dvd = {5'b0, r_e_whole}; ld_dvsr = r_e_div; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_NAME; r_dl <= RST_LENGTH; r_do <= RST_OCTAVE; r_tb <= RST_TEMPO;
            r_wn <= '0; r_acc <= '0; r_pn <= '0; r_dot <= 1'b0; r_po <= '0; r_og <= 1'b0;
            r_busy <= 1'b0; r_done <= 1'b0; r_o_valid <= 1'b0;
            r_e_note <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_e_whole <= r_wn;
                r_e_div   <= cap_div;
                r_e_bpm   <= tmp_bpm;
                r_e_dot   <= cap_dot;
                r_e_fin   <= i_fin;
                r_e_note  <= emit_note;
                r_e_plain <= !emit_note;
                r_e_freq  <= (cap_noted && idx_ok) ? freq_lookup(cap_idx[5:0]) : 12'd0;
                r_e_rest  <= !(cap_noted && idx_ok);
                r_e_err   <= cap_noted && !idx_ok;
                if (i_fin) begin
                    r_ph <= PH_NAME; r_dl <= RST_LENGTH; r_do <= RST_OCTAVE;
                    r_tb <= RST_TEMPO; r_wn <= '0; r_acc <= '0; r_pn <= '0;
                    r_dot <= 1'b0; r_po <= '0; r_og <= 1'b0;
                end else begin
                    r_ph <= n_ph; r_dl <= n_dl; r_do <= n_do; r_tb <= n_tb;
                    r_acc <= n_acc; r_pn <= n_pn; r_dot <= n_dot; r_po <= n_po;
                    r_og <= n_og;
                end
            end
            if (i_cmd.load_whole) begin
                r_e_whole <= {r_quo[15:0], 2'b0};
                if (!r_e_fin) r_wn <= {r_quo[15:0], 2'b0};
            end
            r_done <= (r_busy && !i_cmd.start && r_cnt == 5'(DIV_STEPS - 1))
                   || (i_cmd.start && i_cmd.sel == SEL_TEN);
            if (i_cmd.start) begin
                if (i_cmd.sel == SEL_TEN) begin
                    r_quo <= {3'b0, hold_prod[43:24]};
                end else begin
                    r_rem  <= '0;
                    r_quo  <= ld_dvd;
                    r_dvsr <= ld_dvsr;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= fits ? (rem_sh - {1'b0, r_dvsr}) : rem_sh;
                r_quo <= {r_quo[21:0], fits};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
                r_o_freq  <= r_e_freq;
                r_o_hold  <= r_e_plain ? 19'd0 : r_quo[18:0];
                r_o_rest  <= r_e_rest;
                r_o_err   <= r_e_err;
                r_o_last  <= r_e_fin;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.hdr_need  = hdr_fin && (!i_fin || emit_note);
        o_sts.emit_note = emit_note;
        o_sts.emit_any  = emit_note || i_fin;
        o_sts.e_note    = r_e_note;
        o_sts.div_done  = r_done;
        o_sts.out_full  = r_o_valid && !i_out_ready;
    end

    assign o_out_valid = r_o_valid;
    assign o_freq      = r_o_freq;
    assign o_hold      = r_o_hold;
    assign o_rest      = r_o_rest;
    assign o_err       = r_o_err;
    assign o_last      = r_o_last;

endmodule

### src/rtttl_note_parser.sv
// ============================================================================
// rtttl_note_parser
// RTTTL ringtone parser: one text character in, at most one note out.
// ============================================================================
// The input stream carries one character per transaction in tdata, with
// tlast marking the final character of a song. The output stream carries
// one note per transaction: frequency, hold time, rest and range flags in
// tdata, and tlast on the note caused by the final character.
// A character that emits nothing is taken without the divider. Ending the
// header runs the shared 23-step divider for the whole note time, and the
// next character is taken once it is done. A note runs that divider once for
// the duration and scales the hold time by a constant multiply in one more
// step; when the header ends on the same character, the header division runs
// first. A final character with no pending note gives a rest.
// The block holds one character at a time. A finished note waits in the
// output register, and a new character is taken meanwhile; only the next
// note waits until that register is free.
// Reset restores the header defaults (length 4, octave 6, tempo 63) and
// empties the output register. The final character of a song restores the same defaults.
// ============================================================================
module rtttl_note_parser
    import rtp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] ch
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata, // [11:0] freq_hz, [30:12] hold_ms,
                                        // [31] is_rest, [32] range_error
    output logic        o_m_axis_tlast
);

    t_cmd        cmd;
    t_sts        sts;
    logic [11:0] freq;
    logic [18:0] hold;
    logic        rest;
    logic        err;

    rtp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rtp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ch        (i_s_axis_tdata),
        .i_fin       (i_s_axis_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_freq      (freq),
        .o_hold      (hold),
        .o_rest      (rest),
        .o_err       (err),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'b0, err, rest, hold, freq};

endmodule

### src/rtp_checker.sv
// ============================================================================
// rtp_checker
// Port-level checks on the ringtone parser.
// ============================================================================
module rtp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output data changed while stalled");

    a_err_is_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[32] |-> o_m_axis_tdata[31])
        else $error("range error without rest");

    a_tone_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[31] |-> o_m_axis_tdata[11:0] != 12'd0)
        else $error("tone with zero frequency");

endmodule

bind rtttl_note_parser rtp_checker u_rtp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
